### src/hts_pkg.sv
`timescale 1ns / 1ps

package hts_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int HASH_W          = 32;
   localparam int BYTE_W          = 8;
   localparam int SLOT_W          = 8;
   localparam int ENTRIES_W       = 9;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 32;
   localparam int DJB_SHIFT       = 5;

   localparam logic [HASH_W-1:0] SEED_RESET = 32'd5381;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 1'b1;

   localparam logic FUNC_STORE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } hts_state_type;

   // completed key, handed from the hash unit to the table controller
   typedef struct packed {
      logic              done;
      logic              func;
      logic [SLOT_W-1:0] slot;
      logic [HASH_W-1:0] hash;
   } hts_key_type;

   // h*33 + byte, byte sign-extended
   function automatic logic [HASH_W-1:0] djb_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] ext;
      ext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
      return (h << DJB_SHIFT) + h + ext;
   endfunction

endpackage

### src/hts_if.sv
`timescale 1ns / 1ps

interface hts_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] key_byte;
   logic       last_byte;
   logic [7:0] slot_index;

   modport source (output valid, func, key_byte, last_byte, slot_index, input ready);
   modport sink   (input valid, func, key_byte, last_byte, slot_index, output ready);
endinterface

interface hts_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [7:0]  match_slot;
   logic [31:0] key_hash;

   modport source (output valid, found, match_slot, key_hash, input ready);
   modport sink   (input valid, found, match_slot, key_hash, output ready);
endinterface

### src/hts_ram.sv
`timescale 1ns / 1ps

module hts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hts_hash.sv
`timescale 1ns / 1ps

module hts_hash (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        func,
   input  logic [hts_pkg::BYTE_W-1:0]  key_byte,
   input  logic                        last_byte,
   input  logic [hts_pkg::SLOT_W-1:0]  slot_index,
   input  logic [hts_pkg::HASH_W-1:0]  seed,
   output hts_pkg::hts_key_type        key
);

   import hts_pkg::*;

   logic [HASH_W-1:0] running_hash_ff, running_hash_in;
   logic              key_open_ff, key_open_in;
   logic [HASH_W-1:0] base;
   logic [HASH_W-1:0] next_hash;

   assign base      = key_open_ff ? running_hash_ff : seed;
   assign next_hash = djb_step(base, key_byte);

   always_comb begin
      running_hash_in = running_hash_ff;
      key_open_in     = key_open_ff;
      if (accept) begin
         running_hash_in = next_hash;
         key_open_in     = !last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_open_ff <= 1'b0;
      end else begin
         key_open_ff <= key_open_in;
      end
   end

   always_ff @(posedge clock) begin
      running_hash_ff <= running_hash_in;
   end

   assign key.done = accept && last_byte;
   assign key.func = func;
   assign key.slot = slot_index;
   assign key.hash = next_hash;

endmodule

### src/hts_ctrl.sv
`timescale 1ns / 1ps

module hts_ctrl #(
   parameter int TABLE_DEPTH = hts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hts_pkg::hts_key_type              key,
   input  logic [hts_pkg::ENTRIES_W-1:0]     entries_in_use,
   output logic                              req_ready,
   output logic                              ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]    ram_wr_addr,
   output logic [hts_pkg::HASH_W-1:0]        ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]    ram_rd_addr,
   input  logic [hts_pkg::HASH_W-1:0]        ram_rd_data,
   hts_rsp_if.source                         rsp
);

   import hts_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = (IDX_W + 1 > ENTRIES_W) ? IDX_W + 1 : ENTRIES_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);

   hts_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              res_found_ff, res_found_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [HASH_W-1:0] res_hash_ff, res_hash_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [HASH_W-1:0] rsp_hash_ff;
   logic              load_out;
   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  key_slot;
   logic              hit;

   assign limit    = (CNT_W'(entries_in_use) > DEPTH_C) ? DEPTH_C : CNT_W'(entries_in_use);
   assign key_slot = CNT_W'(key.slot);
   assign hit      = rd_pend_ff && (ram_rd_data == res_hash_ff);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rd_pend_in   = 1'b0;
      rd_ptr_in    = rd_ptr_ff;
      res_found_in = res_found_ff;
      res_slot_in  = res_slot_ff;
      res_hash_in  = res_hash_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff[IDX_W-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff[IDX_W-1:0];
      load_out     = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (ptr_ff == LAST_C) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (key.done) begin
               res_hash_in = key.hash;
               if (key.func == FUNC_STORE) begin
                  // slots past the table are dropped
                  ram_wr_en    = key_slot < DEPTH_C;
                  ram_wr_addr  = key_slot[IDX_W-1:0];
                  ram_wr_data  = key.hash;
                  res_found_in = 1'b1;
                  res_slot_in  = key.slot;
                  state_in     = ST_DELIVER;
               end else begin
                  ptr_in       = key_slot;
                  res_found_in = 1'b0;
                  res_slot_in  = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_slot_in  = rd_ptr_ff[SLOT_W-1:0];
               state_in     = ST_DELIVER;
            end else if (ptr_ff < limit) begin
               ram_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               rd_ptr_in  = ptr_ff;
               ptr_in     = ptr_ff + 1'b1;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      res_found_ff <= res_found_in;
      res_slot_ff  <= res_slot_in;
      res_hash_ff  <= res_hash_in;
      if (load_out) begin
         rsp_found_ff <= res_found_ff;
         rsp_slot_ff  <= res_slot_ff;
         rsp_hash_ff  <= res_hash_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.match_slot = rsp_slot_ff;
   assign rsp.key_hash   = rsp_hash_ff;

   a_hit_to_deliver: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit) |=> (state_ff == ST_DELIVER && res_found_ff))
      else $error("scan hit not delivered");

   a_hit_in_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit) |-> (rd_ptr_ff < limit))
      else $error("hit beyond search bound");

   a_load_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DELIVER))
      else $error("result appeared outside deliver");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("table write during scan or deliver");

endmodule

### src/hash_table_store_and_search.sv
`timescale 1ns / 1ps

// Seeded DJB hash table, store and search.
// req_chan carries one key byte per item (func, key_byte, last_byte, slot_index);
// rsp_chan returns one item per key: found, match_slot, key_hash.
// csr_*: write enable, index and data; index 0 is hash_seed, 1 is entries_in_use.
// Write configuration only while the block is idle.
// A byte without last_byte is taken and gives no result.
// A store key's last byte: its slot, if in the table, is written as the item is taken.
// A search key's last byte: slots from slot_index up to min(entries_in_use,
// TABLE_DEPTH)-1 are read one per cycle from the table RAM and compared in
// the cycle after; the scan stops early on a hit.
// Either result passes through the deliver state into the output register.
// The next byte can be taken as soon as that result sits in the output register.
// Reset clears the table in a pass over all TABLE_DEPTH slots, during which
// req_chan.ready stays low; csr writes are taken throughout.
// If rsp_chan stalls, the result waits in the output register; bytes of the
// next key are still taken, its last byte too, after which req_chan.ready
// stays low until the output register is free.
module hash_table_store_and_search #(
   parameter int TABLE_DEPTH = hts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   hts_req_if.sink                           req_chan,
   hts_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [hts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import hts_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [HASH_W-1:0]    seed_ff, seed_in;
   logic [ENTRIES_W-1:0] entries_ff, entries_in;
   logic                 req_ready;
   logic                 accept;
   hts_key_type          key;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [HASH_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [HASH_W-1:0]    ram_rd_data;

   always_comb begin
      seed_in    = seed_ff;
      entries_in = entries_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HASH_SEED:      seed_in    = csr_wdata[HASH_W-1:0];
            CSR_ENTRIES_IN_USE: entries_in = csr_wdata[ENTRIES_W-1:0];
            default:            seed_in    = seed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= SEED_RESET;
         entries_ff <= '0;
      end else begin
         seed_ff    <= seed_in;
         entries_ff <= entries_in;
      end
   end

   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;

   hts_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_chan.func),
      .key_byte   (req_chan.key_byte),
      .last_byte  (req_chan.last_byte),
      .slot_index (req_chan.slot_index),
      .seed       (seed_ff),
      .key        (key)
   );

   hts_ram #(
      .WIDTH (HASH_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hts_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .key            (key),
      .entries_in_use (entries_ff),
      .req_ready      (req_ready),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp            (rsp_chan)
   );

endmodule
